[hdl/osswo_pkg.sv]
// ----------------------------------------------------------------------------
// osswo_pkg
// Shared types and constants for the order statistic store with offset.
// ----------------------------------------------------------------------------
package osswo_pkg;

	localparam int CAPACITY = 256;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int AMT_W    = 31;
	localparam int HELD_W   = 9;

	localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_RAISE  = 2'd1;
	localparam logic [1:0] MODE_LOWER  = 2'd2;
	localparam logic [1:0] MODE_QUERY  = 2'd3;

	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_INSERT = 3'd1,
		CELL_SHIFT  = 3'd2,
		CELL_LOAD   = 3'd3,
		CELL_RSHIFT = 3'd4
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t          cmd;
		logic [KEY_W-1:0]   key;
		logic [CNT_W-1:0]   count;
	} cell_ctl_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [AMT_W-1:0]  amount;
	} in_item_t;

	typedef struct packed {
		logic                     answer_valid;
		logic                     not_found;
		logic signed [KEY_W-1:0]  answer_value;
		logic                     insert_dropped;
		logic [HELD_W-1:0]        held_count;
		logic [31:0]              removed_total;
	} out_item_t;

endpackage

[hdl/order_statistic_store_with_offset_top.sv]
// ----------------------------------------------------------------------------
// order_statistic_store_with_offset_top
// Sorted multiset kept in a chain of cells, with a global offset and purge.
// ----------------------------------------------------------------------------
// Path from acceptance to the result beat: insert and raise pass through EXEC and
// DONE; lower adds PURGE, which removes entries below min_level one per cycle;
// a found query adds QSHIFT, with the read lane walking cell (held - k) down to
// cell 0. A new item is accepted the cycle after the result is registered.
// Reset clears the count, offset, purge total, min_level and all control state.
// ----------------------------------------------------------------------------
module order_statistic_store_with_offset_top import osswo_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_data,
	input  logic              cfg_wr_en,
	input  logic [AMT_W-1:0]  cfg_wr_data
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_PURGE  = 5'b00100,
		ST_QSHIFT = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [AMT_W-1:0]  min_level_q;
	logic [1:0]        mode_q;
	logic [AMT_W-1:0]  amount_q;
	logic [CNT_W-1:0]  count_q;
	logic [KEY_W-1:0]  offset_q;
	logic [31:0]       purged_q;
	logic [IDX_W-1:0]  rcnt_q;
	logic              valid_q, nf_q, dropped_q;
	logic [KEY_W-1:0]  answer_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic [KEY_W-1:0]  key_w [CAPACITY];
	logic              lt_w  [CAPACITY];
	logic [KEY_W-1:0]  rd_w  [CAPACITY];

	logic [KEY_W-1:0]  ins_key, thresh;
	logic              admit, full, purge_hit, q_miss, out_free;
	logic [CNT_W-1:0]  q_idx;
	cell_ctl_t         ctl;

	assign ins_key   = ({1'b0, amount_q} - offset_q) ^ SIGN_FLIP;
	assign thresh    = ({1'b0, min_level_q} - offset_q) ^ SIGN_FLIP;
	assign admit     = amount_q >= min_level_q;
	assign full      = count_q == CNT_W'(CAPACITY);
	assign purge_hit = (count_q != '0) && (key_w[0] < thresh);
	assign q_miss    = (amount_q == '0) || (amount_q > AMT_W'(count_q));
	assign q_idx     = count_q - amount_q[CNT_W-1:0];
	assign out_free  = !out_valid_q || !out_stall;

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d   = state_q;
		ctl.cmd   = CELL_HOLD;
		ctl.key   = ins_key;
		ctl.count = count_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (mode_q)
					MODE_INSERT: begin
						state_d = ST_DONE;
						if (admit && !full) begin
							ctl.cmd = CELL_INSERT;
						end
					end
					MODE_RAISE: state_d = ST_DONE;
					MODE_LOWER: state_d = ST_PURGE;
					MODE_QUERY: begin
						if (q_miss) begin
							state_d = ST_DONE;
						end else begin
							ctl.cmd = CELL_LOAD;
							state_d = ST_QSHIFT;
						end
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_PURGE: begin
				if (purge_hit) begin
					ctl.cmd = CELL_SHIFT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_QSHIFT: begin
				if (rcnt_q == '0) begin
					state_d = ST_DONE;
				end else begin
					ctl.cmd = CELL_RSHIFT;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			min_level_q <= '0;
			count_q     <= '0;
			offset_q    <= '0;
			purged_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				min_level_q <= cfg_wr_data;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_EXEC: begin
					unique case (mode_q)
						MODE_INSERT: begin
							if (admit && !full) begin
								count_q <= count_q + 1'b1;
							end
						end
						MODE_RAISE: offset_q <= offset_q + {1'b0, amount_q};
						MODE_LOWER: offset_q <= offset_q - {1'b0, amount_q};
						default: begin
						end
					endcase
				end
				ST_PURGE: begin
					if (purge_hit) begin
						count_q  <= count_q - 1'b1;
						purged_q <= purged_q + 32'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Item and result payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					mode_q    <= in_data.mode;
					amount_q  <= in_data.amount;
					valid_q   <= 1'b0;
					nf_q      <= 1'b0;
					dropped_q <= 1'b0;
					answer_q  <= '0;
				end
			end
			ST_EXEC: begin
				if (mode_q == MODE_INSERT) begin
					dropped_q <= admit && full;
				end
				if (mode_q == MODE_QUERY) begin
					nf_q   <= q_miss;
					rcnt_q <= q_idx[IDX_W-1:0];
				end
			end
			ST_QSHIFT: begin
				if (rcnt_q == '0) begin
					valid_q  <= 1'b1;
					answer_q <= (rd_w[0] ^ SIGN_FLIP) + offset_q;
				end else begin
					rcnt_q <= rcnt_q - 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.answer_valid   <= valid_q;
					out_q.not_found      <= nf_q;
					out_q.answer_value   <= answer_q;
					out_q.insert_dropped <= dropped_q;
					out_q.held_count     <= HELD_W'(count_q);
					out_q.removed_total  <= purged_q;
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_W-1:0] lkey, rkey, rrd;
		logic             llt;
		if (i == 0) begin : g_first
			assign lkey = '0;
			assign llt  = 1'b1;
		end else begin : g_mid
			assign lkey = key_w[i-1];
			assign llt  = lt_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rkey = key_w[i];
			assign rrd  = '0;
		end else begin : g_inner
			assign rkey = key_w[i+1];
			assign rrd  = rd_w[i+1];
		end
		osswo_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.ctl       (ctl),
			.left_key  (lkey),
			.left_lt   (llt),
			.right_key (rkey),
			.right_rd  (rrd),
			.key       (key_w[i]),
			.lt        (lt_w[i]),
			.rd        (rd_w[i])
		);
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_purge_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PURGE && purge_hit) |=> count_q == $past(count_q) - 1'b1)
		else $error("purge step did not drop one entry");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QSHIFT |-> {1'b0, rcnt_q} < count_q)
		else $error("query read index beyond held entries");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result beat raised outside the done state");

	a_full_no_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(full && ctl.cmd == CELL_INSERT) |-> 1'b0)
		else $error("insert issued into a full store");

endmodule

[hdl/osswo_cell.sv]
// ----------------------------------------------------------------------------
// osswo_cell
// One slot of the sorted chain: holds a sign-flipped key and a read lane tap.
// ----------------------------------------------------------------------------
module osswo_cell import osswo_pkg::*; (
	input  logic              clk,
	input  logic [IDX_W-1:0]  idx,
	input  cell_ctl_t         ctl,
	input  logic [KEY_W-1:0]  left_key,
	input  logic              left_lt,
	input  logic [KEY_W-1:0]  right_key,
	input  logic [KEY_W-1:0]  right_rd,
	output logic [KEY_W-1:0]  key,
	output logic              lt,
	output logic [KEY_W-1:0]  rd
);

	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] rd_q;
	logic             occ;

	assign occ = {1'b0, idx} < ctl.count;
	// A slot that holds a smaller key stays; the insert point is the first slot that does not.
	assign lt  = occ && (key_q < ctl.key);
	assign key = key_q;
	assign rd  = rd_q;

	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			CELL_INSERT: begin
				if (!lt) begin
					key_q <= left_lt ? ctl.key : left_key;
				end
			end
			CELL_SHIFT:  key_q <= right_key;
			CELL_LOAD:   rd_q  <= key_q;
			CELL_RSHIFT: rd_q  <= right_rd;
			default: begin
			end
		endcase
	end

endmodule
